// ----- src/mfq_pkg.sv -----
// Package: shared constants, codes and controller/datapath interface types.
package mfq_pkg;
  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_FIFO = 2'd0,
    MODE_LIFO = 2'd1,
    MODE_PRIO = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_LAST = 2'd1,
    RD_SCAN = 2'd2,
    RD_IDLE = 2'd3
  } rd_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    latch;
    logic    exec_simple;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    finish_seq;
    logic    scan_start;
    logic    scan_step;
    logic    finish_prio;
    logic    out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    op_t   op;
    mode_t mode;
    logic  empty;
    logic  scan_done;
    logic  out_free;
  } stat_t;
endpackage

// ----- src/mfq_ctrl.sv -----
// Controller: sequences one item at a time through the datapath.
module mfq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  mfq_pkg::stat_t st,
  output mfq_pkg::cmd_t  cmd
);
  import mfq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RD_WAIT, S_SCAN, S_LAST_WAIT, S_PUT
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  // Next state and command decode
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_IDLE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.op == OP_POP && !st.empty && st.mode == MODE_PRIO) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else if (st.op == OP_POP && !st.empty) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = (st.mode == MODE_LIFO) ? RD_LAST : RD_HEAD;
          state_next = S_RD_WAIT;
        end else begin
          cmd.exec_simple = 1'b1;
          state_next      = S_PUT;
        end
      end
      S_RD_WAIT: begin
        cmd.finish_seq = 1'b1;
        state_next     = S_PUT;
      end
      S_SCAN: begin
        if (st.scan_done) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LAST;
          state_next = S_LAST_WAIT;
        end else begin
          cmd.scan_step = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_SCAN;
        end
      end
      S_LAST_WAIT: begin
        cmd.finish_prio = 1'b1;
        state_next      = S_PUT;
      end
      S_PUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end
endmodule

// ----- src/mfq_dpath.sv -----
// Datapath: entry memory, pointers, priority scan and result register.
module mfq_dpath (
  input  logic                 clk,
  input  logic                 rst,
  input  mfq_pkg::cmd_t        cmd,
  output mfq_pkg::stat_t       st,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  input  logic [1:0]           op,
  input  logic [31:0]          node_id,
  input  logic signed [31:0]   priority_req,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          popped_id,
  output logic                 popped_valid,
  output logic [1:0]           status,
  output logic [6:0]           entry_count,
  output logic                 is_empty
);
  import mfq_pkg::*;

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] wrap_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  // Entry memory: {id, priority}
  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data;
  logic [PTR_W-1:0] rd_addr, wr_addr, rd_addr_q;
  logic        wr_en;
  logic [63:0] wr_data;

  mode_t mode;
  logic [PTR_W-1:0] head, tail, scan_ptr, best_addr;
  logic [CNT_W-1:0] count, scan_left;
  logic        rd_pending, best_set;
  logic [31:0] best_id;
  logic signed [31:0] best_pri;

  op_t         op_q;
  logic [31:0] nid_q;
  logic [31:0] pri_q;
  logic [31:0] res_id;
  logic        res_valid;
  status_t     res_status;

  logic        full, empty, outranks;
  logic [31:0] rd_id;
  logic signed [31:0] rd_pri;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rd_id  = rd_data[63:32];
  assign rd_pri = rd_data[31:0];
  assign outranks = !best_set || (rd_pri > best_pri) ||
                    ((rd_pri == best_pri) && (rd_id > best_id));

  assign st.op        = op_q;
  assign st.mode      = mode;
  assign st.empty     = empty;
  assign st.scan_done = (scan_left == '0) && !rd_pending;
  assign st.out_free  = !out_valid || !out_stall;

  // Read address select
  always_comb begin
    unique case (cmd.rd_sel)
      RD_HEAD: rd_addr = head;
      RD_LAST: rd_addr = wrap_prev(tail);
      RD_SCAN: rd_addr = scan_ptr;
      default: rd_addr = head;
    endcase
  end

  // Write port: push at tail, or move last entry into the removed slot
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail;
    wr_data = {nid_q, pri_q};
    if (cmd.exec_simple && op_q == OP_PUSH && !full) begin
      wr_en = 1'b1;
    end else if (cmd.finish_prio) begin
      wr_en   = 1'b1;
      wr_addr = best_addr;
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en && !(cmd.scan_step && scan_left == '0)) rd_data <= mem[rd_addr];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q  <= op_t'(op);
      nid_q <= node_id;
      pri_q <= priority_req;
    end
    if (cmd.scan_step && scan_left != '0) rd_addr_q <= scan_ptr;
    if (cmd.scan_step && rd_pending && outranks) begin
      best_addr <= rd_addr_q;
      best_id   <= rd_id;
      best_pri  <= rd_pri;
    end
    if (cmd.exec_simple) begin
      res_id     <= '0;
      res_valid  <= 1'b0;
      res_status <= ST_OK;
      if (op_q == OP_PUSH && full)      res_status <= ST_OVERFLOW;
      else if (op_q == OP_POP && empty) res_status <= ST_UNDERFLOW;
    end
    if (cmd.finish_seq) begin
      res_id     <= rd_id;
      res_valid  <= 1'b1;
      res_status <= ST_OK;
    end
    if (cmd.finish_prio) begin
      res_id     <= best_id;
      res_valid  <= 1'b1;
      res_status <= ST_OK;
    end
    if (cmd.out_load) begin
      popped_id    <= res_id;
      popped_valid <= res_valid;
      status       <= res_status;
      entry_count  <= 7'(count);
      is_empty     <= empty;
    end
  end

  // Control registers: mode, pointers, count, scan state, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_FIFO;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      scan_ptr   <= '0;
      scan_left  <= '0;
      rd_pending <= 1'b0;
      best_set   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode  <= (cfg_wdata == MODE_RSVD) ? MODE_FIFO : mode_t'(cfg_wdata);
        head  <= '0;
        tail  <= '0;
        count <= '0;
      end
      if (cmd.exec_simple) begin
        if (op_q == OP_PUSH && !full) begin
          tail  <= wrap_next(tail);
          count <= count + 1'b1;
        end else if (op_q == OP_CLEAR) begin
          head  <= '0;
          tail  <= '0;
          count <= '0;
        end
      end
      if (cmd.finish_seq) begin
        count <= count - 1'b1;
        if (mode == MODE_LIFO) tail <= wrap_prev(tail);
        else                   head <= wrap_next(head);
      end
      if (cmd.finish_prio) begin
        count <= count - 1'b1;
        tail  <= wrap_prev(tail);
      end
      if (cmd.scan_start) begin
        scan_ptr   <= head;
        scan_left  <= count;
        rd_pending <= 1'b0;
        best_set   <= 1'b0;
      end
      if (cmd.scan_step) begin
        rd_pending <= (scan_left != '0);
        if (scan_left != '0) begin
          scan_ptr  <= wrap_next(scan_ptr);
          scan_left <= scan_left - 1'b1;
        end
        if (rd_pending) best_set <= 1'b1;
      end
      if (cmd.out_load)           out_valid <= 1'b1;
      else if (!out_stall)        out_valid <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("entry count above depth");
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (entry_count == 7'd0))) else $error("empty flag mismatch");
  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && popped_valid) |-> (status == ST_OK)) else $error("pop with error status");
endmodule

// ----- src/mode_select_fifo_lifo_priority_queue_top.sv -----
// Top level: scheduler queue with FIFO, LIFO or priority discipline.
//   channel  direction  handshake             payload
//   cfg      in         cfg_we                cfg_wdata (queue mode)
//   in       in         in_valid / in_stall   op, node_id, priority_req
//   out      out        out_valid / out_stall popped_id, popped_valid, status,
//                                             entry_count, is_empty
// Push, clear and error cases run through the execute and put states; FIFO/LIFO
// pop adds a wait state for the registered memory read. Priority pop runs a linear
// scan that reads one entry per cycle through the single memory read port, then
// moves the last entry into the freed slot. One item is in flight at a time.
// Reset (rst, synchronous) empties the queue and selects FIFO; no clearing pass.
// A result held under out_stall keeps the block from finishing the next item.
module mode_select_fifo_lifo_priority_queue_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [31:0]        node_id,
  input  logic signed [31:0] priority_req,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        popped_id,
  output logic               popped_valid,
  output logic [1:0]         status,
  output logic [6:0]         entry_count,
  output logic               is_empty
);
  import mfq_pkg::*;

  cmd_t  cmd;
  stat_t st;

  mfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  mfq_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .op           (op),
    .node_id      (node_id),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_id    (popped_id),
    .popped_valid (popped_valid),
    .status       (status),
    .entry_count  (entry_count),
    .is_empty     (is_empty)
  );
endmodule
